// File: design/acorr_pkg.sv
// ----------------------------------------------------------------------------
// Circular autocorrelation package
// Shared widths, the sequencer state type and the MAC control struct.
// ----------------------------------------------------------------------------
package acorr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int CORR_W   = 38;
    localparam int LAG_W    = 6;
    localparam int CFG_W    = 7;

    // Reset value of the trace length register.
    localparam logic [CFG_W-1:0] TRACE_LENGTH_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_COLLECT = 4'b0001,
        ST_ISSUE   = 4'b0010,
        ST_DRAIN   = 4'b0100,
        ST_DELIVER = 4'b1000
    } state_t;

    // One multiply-add request travelling down the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// File: design/acorr_channels.sv
// ----------------------------------------------------------------------------
// Circular autocorrelation channels
// Valid/ready interfaces for the sample input and the lag result output.
// ----------------------------------------------------------------------------
interface acorr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [acorr_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface acorr_out_if;
    logic                                valid;
    logic                                ready;
    logic [acorr_pkg::LAG_W-1:0]          lag_index;
    logic signed [acorr_pkg::CORR_W-1:0]  correlation;
    logic                                final_lag;

    modport source (output valid, output lag_index, output correlation, output final_lag,
                    input ready);
    modport sink   (input valid, input lag_index, input correlation, input final_lag,
                    output ready);
endinterface

// File: design/acorr_store.sv
// ----------------------------------------------------------------------------
// Circular autocorrelation trace store
// Sample memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module acorr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [AW-1:0]                         wr_addr,
    input  logic signed [acorr_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [AW-1:0]                         rd_addr_a,
    input  logic [AW-1:0]                         rd_addr_b,
    output logic signed [acorr_pkg::SAMPLE_W-1:0] rd_data_a,
    output logic signed [acorr_pkg::SAMPLE_W-1:0] rd_data_b
);

    logic signed [acorr_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: design/acorr_mac.sv
// ----------------------------------------------------------------------------
// Circular autocorrelation MAC unit
// Shared multiply-accumulate: registered product, then accumulation.
// ----------------------------------------------------------------------------
module acorr_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  acorr_pkg::mac_ctl_t                   ctl,
    input  logic signed [acorr_pkg::SAMPLE_W-1:0] a,
    input  logic signed [acorr_pkg::SAMPLE_W-1:0] b,
    output logic signed [acorr_pkg::CORR_W-1:0]   result,
    output logic                                  done
);

    localparam int CorrW = acorr_pkg::CORR_W;

    // The request arrives with the read addresses; the data follows in the cycle after.
    acorr_pkg::mac_ctl_t                 ctl_d1_reg;
    acorr_pkg::mac_ctl_t                 ctl_d2_reg;
    logic signed [acorr_pkg::PROD_W-1:0] prod_reg;
    logic signed [CorrW-1:0]             acc_reg;
    logic signed [CorrW-1:0]             acc_next;
    logic                                done_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl_d2_reg.valid)
        begin
            if (ctl_d2_reg.first)
            begin
                acc_next = CorrW'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + CorrW'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d1_reg <= '0;
            ctl_d2_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ctl_d1_reg <= ctl;
            ctl_d2_reg <= ctl_d1_reg;
            done_reg   <= ctl_d2_reg.valid && ctl_d2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    assign result = acc_reg;
    assign done   = done_reg;

endmodule

// File: design/trace_circular_autocorrelation_top.sv
// ----------------------------------------------------------------------------
// Trace circular autocorrelation, top level
// Collects one trace and emits r[k] = sum x[n]*x[(n+k) mod N] for every lag.
// ----------------------------------------------------------------------------
// Usage: samples arrive on in_ch, one per transfer, and are written to the
// trace store. After the N-th sample (N is trace_length, a value of zero is
// taken as 1 and values above MAX_SAMPLES are clipped) the block stops taking
// samples and computes the N lags one after another on a single shared
// multiply-accumulate unit. For each lag the sequencer issues N products,
// which pass through store read, product and accumulate before the sum
// moves into the output register. Results leave on out_ch as lag_index,
// correlation and final_lag, with final_lag high on lag N-1. If the receiver
// stalls, the previous sum waits in the output register, the new sum waits in
// the MAC accumulator and the sequencer holds before starting the next lag;
// once the last lag is in the output register, new samples are taken at once,
// one per cycle.
// Reset clears the sample count and sets trace_length to 64; the store itself
// is not cleared since every entry is written before it is read. Writing
// trace_length through cfg_write_en discards a partially collected trace.
// ----------------------------------------------------------------------------
module trace_circular_autocorrelation_top #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [acorr_pkg::CFG_W-1:0]      cfg_write_data,
    acorr_in_if.sink                         in_ch,
    acorr_out_if.source                      out_ch
);

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int CfgW  = acorr_pkg::CFG_W;
    localparam int LagW  = acorr_pkg::LAG_W;
    localparam int CorrW = acorr_pkg::CORR_W;

    // Sequencer and collection state.
    acorr_pkg::state_t   state_reg;
    acorr_pkg::state_t   state_next;
    logic [CfgW-1:0]     trace_length_reg;
    logic [CfgW-1:0]     trace_length_next;
    logic [CW-1:0]       loaded_reg;
    logic [CW-1:0]       loaded_next;
    logic [AW-1:0]       i_reg;
    logic [AW-1:0]       i_next;
    logic [AW-1:0]       j_reg;
    logic [AW-1:0]       j_next;
    logic [AW-1:0]       k_reg;
    logic [AW-1:0]       k_next;

    // Output register.
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [LagW-1:0]         out_lag_reg;
    logic signed [CorrW-1:0] out_corr_reg;
    logic                    out_final_reg;
    logic                    out_load;

    // Effective trace length and its last index.
    logic [CW-1:0] n_eff;
    logic [CW-1:0] n_m1;
    logic [CW-1:0] count;

    logic                                  in_xfer;
    logic                                  wr_en;
    logic [AW-1:0]                         wr_addr;
    logic signed [acorr_pkg::SAMPLE_W-1:0] rd_data_a;
    logic signed [acorr_pkg::SAMPLE_W-1:0] rd_data_b;
    acorr_pkg::mac_ctl_t                   mac_ctl;
    logic signed [CorrW-1:0]               mac_result;
    logic                                  mac_done;

    always_comb
    begin
        if (trace_length_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (trace_length_reg > CfgW'(MAX_SAMPLES))
        begin
            n_eff = CW'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = CW'(trace_length_reg);
        end
        n_m1 = n_eff - CW'(1);
    end

    assign in_ch.ready = (state_reg == acorr_pkg::ST_COLLECT);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // A count that is not below N restarts collection at entry zero.
    assign count   = (loaded_reg >= n_eff) ? CW'(1) : (loaded_reg + CW'(1));
    assign wr_en   = in_xfer;
    assign wr_addr = (loaded_reg >= n_eff) ? '0 : loaded_reg[AW-1:0];

    always_comb
    begin
        state_next        = state_reg;
        trace_length_next = trace_length_reg;
        loaded_next       = loaded_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        mac_ctl           = '0;
        out_load          = 1'b0;

        unique case (state_reg)
            acorr_pkg::ST_COLLECT:
            begin
                if (in_xfer)
                begin
                    loaded_next = count;
                    if (count == n_eff)
                    begin
                        state_next = acorr_pkg::ST_ISSUE;
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                    end
                end
            end
            acorr_pkg::ST_ISSUE:
            begin
                // One product x[i]*x[(i+k) mod N] per cycle.
                mac_ctl.valid = 1'b1;
                mac_ctl.first = (i_reg == '0);
                mac_ctl.last  = (CW'(i_reg) == n_m1);
                if (mac_ctl.last)
                begin
                    state_next = acorr_pkg::ST_DRAIN;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                    j_next = (CW'(j_reg) == n_m1) ? '0 : (j_reg + AW'(1));
                end
            end
            acorr_pkg::ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = acorr_pkg::ST_DELIVER;
                end
            end
            acorr_pkg::ST_DELIVER:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load = 1'b1;
                    if (CW'(k_reg) == n_m1)
                    begin
                        state_next  = acorr_pkg::ST_COLLECT;
                        loaded_next = '0;
                    end
                    else
                    begin
                        state_next = acorr_pkg::ST_ISSUE;
                        k_next     = k_reg + AW'(1);
                        i_next     = '0;
                        j_next     = k_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = acorr_pkg::ST_COLLECT;
            end
        endcase

        // The user writes configuration only while idle (not enforced); a write drops any partial trace.
        if (cfg_write_en)
        begin
            trace_length_next = cfg_write_data;
            loaded_next       = '0;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= acorr_pkg::ST_COLLECT;
            trace_length_reg <= acorr_pkg::TRACE_LENGTH_RESET;
            loaded_reg       <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            trace_length_reg <= trace_length_next;
            loaded_reg       <= loaded_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_lag_reg   <= LagW'(k_reg);
            out_corr_reg  <= mac_result;
            out_final_reg <= (CW'(k_reg) == n_m1);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.lag_index   = out_lag_reg;
    assign out_ch.correlation = out_corr_reg;
    assign out_ch.final_lag   = out_final_reg;

    acorr_store #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (in_ch.sample),
        .rd_addr_a (i_reg),
        .rd_addr_b (j_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    acorr_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a      (rd_data_a),
        .b      (rd_data_b),
        .result (mac_result),
        .done   (mac_done)
    );

`ifndef SYNTHESIS
    // A finished sum only appears while the sequencer waits for it.
    ap_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == acorr_pkg::ST_DRAIN)
        else $error("MAC finished outside the drain state");

    // The sample count never exceeds the trace length.
    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= n_eff)
        else $error("sample count beyond trace length");

    // Both read indexes stay inside the trace while products are issued.
    ap_issue_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == acorr_pkg::ST_ISSUE |-> (CW'(i_reg) <= n_m1) && (CW'(j_reg) <= n_m1))
        else $error("read index outside the trace");
`endif

endmodule
